[rtl/servo_sync_write_framer_assert.svh]
// Assertion macros for the servo sync-write framer.
// Taken in by `include; no other dependencies.
`ifndef SERVO_SYNC_WRITE_FRAMER_ASSERT_SVH
`define SERVO_SYNC_WRITE_FRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define SSW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define SSW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSW_ASSERT(lbl, clk, rst, prop, msg)
`define SSW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/ssw_pkg.sv]
// Shared types, constants and functions of the servo sync-write framer.
// No dependencies.
package ssw_pkg;

   // register indexes on the csr channel
   localparam logic [1:0] CSR_PACKET_ID     = 2'd0;
   localparam logic [1:0] CSR_START_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_MOTOR_COUNT   = 2'd2;

   localparam logic [7:0]  PACKET_ID_RST     = 8'hFE;
   localparam logic [15:0] START_ADDRESS_RST = 16'h0070;
   localparam logic [4:0]  MOTOR_COUNT_RST   = 5'd4;

   localparam logic [7:0]  HDR_SYNC         = 8'hFF;
   localparam logic [7:0]  HDR_MARK         = 8'hFD;
   localparam logic [7:0]  HDR_RESERVED     = 8'h00;
   localparam logic [7:0]  INSTR_SYNC_WRITE = 8'h83;
   localparam logic [7:0]  ENTRY_DATA_LEN   = 8'h08;
   localparam logic [15:0] CRC_POLY         = 16'h8005;
   localparam logic [15:0] LEN_EXTRA        = 16'd7;

   // byte positions within the frame of one item (header, then entry)
   localparam logic [4:0]  FIRST_ENTRY_BYTE = 5'd12;
   localparam logic [4:0]  LAST_BYTE        = 5'd20;

   typedef struct packed {
      logic        hdr;
      logic        last;
      logic [7:0]  packet_id;
      logic [15:0] start_address;
      logic [15:0] length;
      logic [7:0]  motor_id;
      logic [31:0] profile_velocity;
      logic [31:0] goal_position;
   } desc_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] frame_byte(input desc_type d, input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0, 5'd1: b = HDR_SYNC;
         5'd2:       b = HDR_MARK;
         5'd3:       b = HDR_RESERVED;
         5'd4:       b = d.packet_id;
         5'd5:       b = d.length[7:0];
         5'd6:       b = d.length[15:8];
         5'd7:       b = INSTR_SYNC_WRITE;
         5'd8:       b = d.start_address[7:0];
         5'd9:       b = d.start_address[15:8];
         5'd10:      b = ENTRY_DATA_LEN;
         5'd11:      b = 8'h00;
         5'd12:      b = d.motor_id;
         5'd13:      b = d.profile_velocity[7:0];
         5'd14:      b = d.profile_velocity[15:8];
         5'd15:      b = d.profile_velocity[23:16];
         5'd16:      b = d.profile_velocity[31:24];
         5'd17:      b = d.goal_position[7:0];
         5'd18:      b = d.goal_position[15:8];
         5'd19:      b = d.goal_position[23:16];
         5'd20:      b = d.goal_position[31:24];
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[rtl/ssw_if.sv]
// Channel interfaces of the servo sync-write framer: entry, byte and csr channels.
// No dependencies.
interface ssw_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  motor_id;
   logic [31:0] profile_velocity;
   logic [31:0] goal_position;
   modport source(output valid, motor_id, profile_velocity, goal_position, input ready);
   modport sink(input valid, motor_id, profile_velocity, goal_position, output ready);
endinterface

interface ssw_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  packet_byte;
   logic        packet_done;
   logic [15:0] crc_value;
   modport source(output valid, packet_byte, packet_done, crc_value, input ready);
   modport sink(input valid, packet_byte, packet_done, crc_value, output ready);
endinterface

interface ssw_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[rtl/ssw_front.sv]
// Front end: csr registers, entry counting and classification of each entry beat.
// Uses ssw_pkg and the channel interfaces.
module ssw_front #(
   parameter int MAX_MOTORS = 16
) (
   input  logic              clock,
   input  logic              reset,
   ssw_req_if.sink           req_ch,
   ssw_csr_if.sink           csr_ch,
   output logic              push,
   output ssw_pkg::desc_type push_desc,
   input  logic              q_full
);
   logic [7:0]  packet_id_ff, packet_id_in;
   logic [15:0] start_address_ff, start_address_in;
   logic [4:0]  motor_count_ff, motor_count_in;
   logic [4:0]  entry_cnt_ff, entry_cnt_in;
   logic [4:0]  count_eff;
   logic        last;
   logic [15:0] length;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;

   always_comb begin
      packet_id_in     = packet_id_ff;
      start_address_in = start_address_ff;
      motor_count_in   = motor_count_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            ssw_pkg::CSR_PACKET_ID:     packet_id_in     = csr_ch.data[7:0];
            ssw_pkg::CSR_START_ADDRESS: start_address_in = csr_ch.data;
            ssw_pkg::CSR_MOTOR_COUNT:   motor_count_in   = csr_ch.data[4:0];
            default: ;
         endcase
      end
   end

   // zero counts as one, anything above the limit as the limit
   always_comb begin
      if (motor_count_ff == 5'd0) begin
         count_eff = 5'd1;
      end else if (motor_count_ff > 5'(MAX_MOTORS)) begin
         count_eff = 5'(MAX_MOTORS);
      end else begin
         count_eff = motor_count_ff;
      end
   end

   assign length = ({11'd0, count_eff} << 3) + {11'd0, count_eff} + ssw_pkg::LEN_EXTRA;
   assign last   = ({1'b0, entry_cnt_ff} + 6'd1) >= {1'b0, count_eff};

   always_comb begin
      entry_cnt_in = entry_cnt_ff;
      if (push) begin
         entry_cnt_in = last ? 5'd0 : entry_cnt_ff + 5'd1;
      end
   end

   always_comb begin
      push_desc.hdr              = (entry_cnt_ff == 5'd0);
      push_desc.last             = last;
      push_desc.packet_id        = packet_id_ff;
      push_desc.start_address    = start_address_ff;
      push_desc.length           = length;
      push_desc.motor_id         = req_ch.motor_id;
      push_desc.profile_velocity = req_ch.profile_velocity;
      push_desc.goal_position    = req_ch.goal_position;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_id_ff     <= ssw_pkg::PACKET_ID_RST;
         start_address_ff <= ssw_pkg::START_ADDRESS_RST;
         motor_count_ff   <= ssw_pkg::MOTOR_COUNT_RST;
         entry_cnt_ff     <= 5'd0;
      end else begin
         packet_id_ff     <= packet_id_in;
         start_address_ff <= start_address_in;
         motor_count_ff   <= motor_count_in;
         entry_cnt_ff     <= entry_cnt_in;
      end
   end
endmodule

[rtl/ssw_queue.sv]
// Two-entry descriptor queue between the front end and the byte sequencer.
// Uses ssw_pkg.
module ssw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ssw_pkg::desc_type push_desc,
   output logic              full,
   output logic              pop_valid,
   output ssw_pkg::desc_type pop_desc,
   input  logic              pop
);
   ssw_pkg::desc_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_desc  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

[rtl/ssw_back.sv]
// Byte sequencer: walks header and entry bytes, runs the CRC, drives the byte channel.
// Uses ssw_pkg and the channel interfaces.
module ssw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ssw_pkg::desc_type q_desc,
   output logic              pop,
   ssw_rsp_if.source         rsp_ch
);
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_done_ff;
   logic [15:0] rsp_crc_ff;
   logic        started_ff, started_in;
   logic [4:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [4:0]  cur_idx;
   logic [7:0]  cur_byte;
   logic [15:0] crc_base;
   logic        load;
   logic        entry_end;
   logic        done;

   // an entry without header starts at the motor id byte
   assign cur_idx   = started_ff ? idx_ff :
                      (q_desc.hdr ? 5'd0 : ssw_pkg::FIRST_ENTRY_BYTE);
   assign cur_byte  = ssw_pkg::frame_byte(q_desc, cur_idx);
   assign crc_base  = (cur_idx == 5'd0) ? 16'd0 : crc_ff;
   assign crc_in    = load ? ssw_pkg::crc_byte(crc_base, cur_byte) : crc_ff;
   assign load      = q_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign entry_end = (cur_idx == ssw_pkg::LAST_BYTE);
   assign done      = entry_end && q_desc.last;
   assign pop       = load && entry_end;

   assign started_in   = load ? !entry_end : started_ff;
   assign idx_in       = load ? cur_idx + 5'd1 : idx_ff;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.packet_byte = rsp_byte_ff;
   assign rsp_ch.packet_done = rsp_done_ff;
   assign rsp_ch.crc_value   = rsp_crc_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= cur_byte;
         rsp_done_ff <= done;
         rsp_crc_ff  <= done ? crc_in : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         idx_ff       <= 5'd0;
         crc_ff       <= 16'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
      end
   end
endmodule

[rtl/servo_sync_write_framer.sv]
// Servo sync-write framer: one motor entry beat in, packet bytes out, one byte a cycle
// unless stalled. req_ch carries motor_id, profile_velocity and goal_position; rsp_ch
// carries one packet byte per beat; packet_done marks the final byte, and crc_value
// then holds the CRC-16 (poly 0x8005, init 0) over every byte of the packet, else 0.
// csr_ch writes packet_id (index 0), start_address (1) and motor_count (2); always
// ready. Users must see it is written only while the framer is idle; nothing checks it.
// The first entry of a packet produces 21 bytes (12-byte header plus entry), the
// others 9. The byte sequencer emits one byte per cycle unless the output stalls;
// the rate is set by the single byte-wide output.
// An accepted entry goes into the queue, then its first byte into the output register.
// A two-deep entry queue lets the front accept entries while bytes are stalled.
// While rsp_ch.ready is low a pending byte holds, the sequencer stops, and once the
// queue is full req_ch.ready drops.
// Reset (synchronous) restores the register defaults (254, 112, 4), empties the
// queue and output, and starts the next entry as the first of a packet.
`include "servo_sync_write_framer_assert.svh"
module servo_sync_write_framer #(
   parameter int MAX_MOTORS = 16
) (
   input logic       clock,
   input logic       reset,
   ssw_req_if.sink   req_ch,
   ssw_rsp_if.source rsp_ch,
   ssw_csr_if.sink   csr_ch
);
   logic              push;
   ssw_pkg::desc_type push_desc;
   logic              q_full;
   logic              q_valid;
   ssw_pkg::desc_type q_desc;
   logic              pop;
   logic              crc_clean;

   ssw_front #(
      .MAX_MOTORS(MAX_MOTORS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .push      (push),
      .push_desc (push_desc),
      .q_full    (q_full)
   );

   ssw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_desc  (q_desc),
      .pop       (pop)
   );

   ssw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_desc  (q_desc),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

   assign crc_clean = rsp_ch.packet_done || (rsp_ch.crc_value == 16'd0);

   `SSW_ASSERT(a_pop_nonempty, clock, reset, pop |-> q_valid, "pop from empty queue")
   `SSW_ASSERT(a_push_not_full, clock, reset, push |-> !q_full, "push into full queue")
   `SSW_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_ch.valid, "byte valid after reset")
   `SSW_ASSERT(a_crc_only_done, clock, reset, rsp_ch.valid |-> crc_clean, "crc on non-final byte")
endmodule

[bench/servo_sync_write_framer_tb.sv]
// Self-checking bench for servo_sync_write_framer: directed table, then random phases.
// Depends on ssw_pkg (rtl/ssw_pkg.sv) and the channel interfaces in rtl/ssw_if.sv.
module servo_sync_write_framer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_MOTORS    = 16;
   localparam int TOTAL_ITEMS   = 320;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [7:0]  data;
      logic        done;
      logic [15:0] crc;
   } byte_beat_type;

   typedef enum logic {ROW_CSR, ROW_ENTRY} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   reg_idx;
      logic [15:0]  wdata;
      logic [7:0]   id;
      logic [31:0]  vel;
      logic [31:0]  pos;
      int           len_field;   // typed length field, -1 when not given
      int           n_bytes;     // typed byte count, 0 when not given
   } stim_row_type;

   localparam int N_ROWS = 29;

   logic clock;
   logic reset;

   ssw_req_if req_ch();
   ssw_rsp_if rsp_ch();
   ssw_csr_if csr_ch();

   servo_sync_write_framer #(.MAX_MOTORS(MAX_MOTORS)) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // predictor state
   logic [7:0]    reg_packet_id;
   logic [15:0]   reg_start_addr;
   logic [4:0]    reg_motor_count;
   logic [15:0]   crc_acc;
   logic [4:0]    entries_in_packet;
   byte_beat_type frame_stage[21];
   int            frame_len;

   byte_beat_type expected_bytes[$];
   stim_row_type  dir_rows[N_ROWS];

   int mismatches;
   int entries_sent;
   int bytes_checked;
   int packets_seen;
   int csr_writes;
   int burst_left;
   int unsigned cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected", cycles,
                  expected_bytes.size());
         $display("servo_sync_write_framer_tb: FAIL");
         $finish;
      end
   end

   function automatic void note_mismatch(input string what, input int exp_v, input int act_v);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch %s: expected 0x%0h, got 0x%0h (beat %0d)", what, exp_v, act_v,
                  bytes_checked);
   endfunction

   // MSB-first CRC-16, poly 0x8005, one bit at a time
   function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ d[i];
         r  = {r[14:0], 1'b0};
         if (fb) r = r ^ ssw_pkg::CRC_POLY;
      end
      return r;
   endfunction

   function automatic void stage_byte(input logic [7:0] b);
      crc_acc = crc16_next(crc_acc, b);
      frame_stage[frame_len] = '{data: b, done: 1'b0, crc: 16'h0000};
      frame_len++;
   endfunction

   // Expected bytes of one motor entry; returns the byte count, length field via len_sent.
   function automatic int frame_entry(input logic [7:0] id, input logic [31:0] vel,
                                      input logic [31:0] pos, output int len_sent);
      int          eff;
      logic [15:0] len;
      eff       = reg_motor_count;
      if (eff < 1) eff = 1;
      if (eff > MAX_MOTORS) eff = MAX_MOTORS;
      frame_len = 0;
      len_sent  = -1;
      if (entries_in_packet == 5'd0) begin
         len      = 16'(9 * eff) + ssw_pkg::LEN_EXTRA;
         len_sent = len;
         crc_acc  = 16'h0000;
         stage_byte(ssw_pkg::HDR_SYNC);
         stage_byte(ssw_pkg::HDR_SYNC);
         stage_byte(ssw_pkg::HDR_MARK);
         stage_byte(ssw_pkg::HDR_RESERVED);
         stage_byte(reg_packet_id);
         stage_byte(len[7:0]);
         stage_byte(len[15:8]);
         stage_byte(ssw_pkg::INSTR_SYNC_WRITE);
         stage_byte(reg_start_addr[7:0]);
         stage_byte(reg_start_addr[15:8]);
         stage_byte(ssw_pkg::ENTRY_DATA_LEN);
         stage_byte(8'h00);
      end
      stage_byte(id);
      for (int k = 0; k < 4; k++) stage_byte(vel[8*k +: 8]);
      for (int k = 0; k < 4; k++) stage_byte(pos[8*k +: 8]);
      entries_in_packet = entries_in_packet + 5'd1;
      // live count: the packet closes once the counter reaches or passes it
      if (entries_in_packet >= eff || entries_in_packet == 5'd0) begin
         frame_stage[frame_len-1].done = 1'b1;
         frame_stage[frame_len-1].crc  = crc_acc;
         entries_in_packet = 5'd0;
         crc_acc = 16'h0000;
      end
      for (int i = 0; i < frame_len; i++) expected_bytes.push_back(frame_stage[i]);
      return frame_len;
   endfunction

   // byte channel checker
   always @(posedge clock) begin
      byte_beat_type exp_b;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            note_mismatch("unexpected byte", 0, rsp_ch.packet_byte);
         end else begin
            exp_b = expected_bytes.pop_front();
            if (rsp_ch.packet_byte !== exp_b.data)
               note_mismatch("packet_byte", exp_b.data, rsp_ch.packet_byte);
            if (rsp_ch.packet_done !== exp_b.done)
               note_mismatch("packet_done", exp_b.done, rsp_ch.packet_done);
            if (rsp_ch.crc_value !== exp_b.crc)
               note_mismatch("crc_value", exp_b.crc, rsp_ch.crc_value);
            if (exp_b.done) packets_seen++;
         end
         bytes_checked++;
      end
   end

   // byte receiver: its stall mode is drawn at random from four modes
   int rx_mode;
   int rx_left;
   int rx_phase;
   always @(posedge clock) begin
      rx_phase <= (rx_phase == 2) ? 0 : rx_phase + 1;
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_left <= $urandom_range(40, 200);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         2:       rsp_ch.ready <= (rx_phase != 0);
         default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         ssw_pkg::CSR_PACKET_ID:     reg_packet_id   = value[7:0];
         ssw_pkg::CSR_START_ADDRESS: reg_start_addr  = value;
         ssw_pkg::CSR_MOTOR_COUNT:   reg_motor_count = value[4:0];
         default:                    ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic send_entry(input logic [7:0] id, input logic [31:0] vel,
                             input logic [31:0] pos, output int n_bytes, output int len_sent);
      req_ch.valid            <= 1'b1;
      req_ch.motor_id         <= id;
      req_ch.profile_velocity <= vel;
      req_ch.goal_position    <= pos;
      do @(posedge clock); while (!req_ch.ready);
      n_bytes = frame_entry(id, vel, pos, len_sent);
      entries_sent++;
   endtask

   // bursts of random length with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] rand_count();
      case ($urandom_range(0, 9))
         6:       return 16'd0;
         7:       return 16'd16;
         8:       return 16'($urandom_range(17, 31));
         9:       return 16'($urandom_range(0, 16'hFFFF));
         default: return 16'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      int nb;
      int lf;
      int eff;
      int n_phase;

      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.motor_id         <= 8'h00;
      req_ch.profile_velocity <= 32'h0;
      req_ch.goal_position    <= 32'h0;
      csr_ch.valid            <= 1'b0;
      csr_ch.index            <= ssw_pkg::CSR_PACKET_ID;
      csr_ch.data             <= 16'h0;
      reg_packet_id     = ssw_pkg::PACKET_ID_RST;
      reg_start_addr    = ssw_pkg::START_ADDRESS_RST;
      reg_motor_count   = ssw_pkg::MOTOR_COUNT_RST;
      crc_acc           = 16'h0000;
      entries_in_packet = 5'd0;
      burst_left        = 0;

      dir_rows = '{
         // reset settings: id 254, address 0x70, four entries, length 43
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h00, 32'h0000_0000, 32'h0000_0000, 43, 21},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, 9},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h01, 32'h8000_0000, 32'h0000_0001, -1, 9},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h80, 32'h1234_5678, 32'h9ABC_DEF0, -1, 9},
         '{ROW_CSR, ssw_pkg::CSR_PACKET_ID, 16'h0000, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_CSR, ssw_pkg::CSR_START_ADDRESS, 16'hFFFF, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_CSR, ssw_pkg::CSR_MOTOR_COUNT, 16'h0001, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h5A, 32'h5555_5555, 32'hAAAA_AAAA, 16, 21},
         // zero count acts as one
         '{ROW_CSR, ssw_pkg::CSR_MOTOR_COUNT, 16'h0000, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'hA5, 32'hAAAA_AAAA, 32'h5555_5555, 16, 21},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h3C, 32'h0000_FFFF, 32'hFFFF_0000, 16, 21},
         '{ROW_CSR, ssw_pkg::CSR_PACKET_ID, 16'h00FF, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_CSR, ssw_pkg::CSR_START_ADDRESS, 16'h0000, 8'h0, 32'h0, 32'h0, -1, 0},
         // over-range count clamps to the maximum
         '{ROW_CSR, ssw_pkg::CSR_MOTOR_COUNT, 16'h001F, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h10, 32'h0000_0001, 32'h8000_0000, 151, 21},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h11, 32'h7FFF_FFFF, 32'hFFFF_FFFE, -1, 9},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h12, 32'h0102_0304, 32'hF0E0_D0C0, -1, 9},
         // count dropped below entries already sent: next entry closes the packet
         '{ROW_CSR, ssw_pkg::CSR_MOTOR_COUNT, 16'h0002, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h13, 32'hDEAD_BEEF, 32'hCAFE_F00D, -1, 9},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h14, 32'h0000_0000, 32'hFFFF_FFFF, 25, 21},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h15, 32'hFFFF_FFFF, 32'h0000_0000, -1, 9},
         // upper data bits beyond the register width are dropped
         '{ROW_CSR, ssw_pkg::CSR_PACKET_ID, 16'h1234, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_CSR, ssw_pkg::CSR_MOTOR_COUNT, 16'hFFE3, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_CSR, ssw_pkg::CSR_START_ADDRESS, 16'h8001, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h16, 32'h8765_4321, 32'h0F0F_0F0F, 34, 21},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h17, 32'hF0F0_F0F0, 32'h1357_9BDF, -1, 9},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h18, 32'h2468_ACE0, 32'hFEDC_BA98, -1, 9},
         '{ROW_CSR, ssw_pkg::CSR_MOTOR_COUNT, 16'h0011, 8'h0, 32'h0, 32'h0, -1, 0},
         '{ROW_ENTRY, ssw_pkg::CSR_PACKET_ID, 16'h0, 8'h19, 32'h0F1E_2D3C, 32'h4B5A_6978, 151, 21}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_ROWS; r++) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            req_ch.valid <= 1'b0;
            wait_drained();
            write_reg(dir_rows[r].reg_idx, dir_rows[r].wdata);
         end else begin
            send_entry(dir_rows[r].id, dir_rows[r].vel, dir_rows[r].pos, nb, lf);
            if (dir_rows[r].len_field >= 0 && lf != dir_rows[r].len_field)
               note_mismatch("length field", dir_rows[r].len_field, lf);
            if (dir_rows[r].n_bytes > 0 && nb != dir_rows[r].n_bytes)
               note_mismatch("bytes per entry", dir_rows[r].n_bytes, nb);
            pace_sender();
         end
      end

      // random phases; settings change only with the byte stream drained
      while (entries_sent < TOTAL_ITEMS) begin
         req_ch.valid <= 1'b0;
         wait_drained();
         if ($urandom_range(0, 2) == 0)
            write_reg(ssw_pkg::CSR_PACKET_ID, ($urandom_range(0, 3) == 0) ? 16'h00FF :
                      16'($urandom_range(0, 16'hFFFF)));
         if ($urandom_range(0, 2) == 0)
            write_reg(ssw_pkg::CSR_START_ADDRESS, ($urandom_range(0, 3) == 0) ? 16'h0000 :
                      16'($urandom_range(0, 16'hFFFF)));
         if ($urandom_range(0, 1) == 0)
            write_reg(ssw_pkg::CSR_MOTOR_COUNT, rand_count());
         eff = reg_motor_count;
         if (eff < 1) eff = 1;
         if (eff > MAX_MOTORS) eff = MAX_MOTORS;
         n_phase = $urandom_range(1, 2 * eff + 2);
         for (int i = 0; i < n_phase && entries_sent < TOTAL_ITEMS; i++) begin
            send_entry(8'($urandom_range(0, 255)), rand_word(), rand_word(), nb, lf);
            pace_sender();
            if ($urandom_range(0, 40) == 0) begin
               req_ch.valid <= 1'b0;
               wait_drained();
            end
         end
      end

      req_ch.valid <= 1'b0;
      wait_drained();
      if (expected_bytes.size() != 0)
         note_mismatch("bytes never sent", expected_bytes.size(), 0);

      $display("run: %0d entries, %0d bytes and %0d packets checked, %0d register writes",
               entries_sent, bytes_checked, packets_seen, csr_writes);
      $display("run: counts 0..31 incl. clamped and mid-packet changes; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("servo_sync_write_framer_tb: PASS");
      end else begin
         $display("servo_sync_write_framer_tb: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/ssw_pkg.sv
rtl/ssw_if.sv
rtl/ssw_front.sv
rtl/ssw_queue.sv
rtl/ssw_back.sv
rtl/servo_sync_write_framer.sv
bench/servo_sync_write_framer_tb.sv
